FILE: src/analog_comparator_with_edge_flag_unit_assert.svh
// Assertion macros for the analog comparator unit.
`ifndef ANALOG_COMPARATOR_WITH_EDGE_FLAG_UNIT_ASSERT_SVH
`define ANALOG_COMPARATOR_WITH_EDGE_FLAG_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define ACEF_ASSERT_HOLDS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("acef: invariant violated");
`define ACEF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("acef: same-cycle implication violated");
`define ACEF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("acef: next-cycle implication violated");
`else
`define ACEF_ASSERT_HOLDS(lbl, clk, rstn, prop)
`define ACEF_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ACEF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: src/acef_pkg.sv
// Types and constants shared by the analog comparator unit.
package acef_pkg;

  localparam int unsigned VOLT_BITS  = 16;  // default stored voltage code width
  localparam int unsigned IN_VOLT_W  = 16;  // voltage field width on the channels
  localparam int unsigned PIN_COUNT  = 10;
  localparam int unsigned PIN_IDX_W  = 4;
  localparam int unsigned ADC_BASE   = 2;   // ADC0 sits after AIN0 and AIN1
  localparam int unsigned CHAN_W     = 3;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [PIN_IDX_W-1:0] PIN_AIN0 = PIN_IDX_W'(0);
  localparam logic [PIN_IDX_W-1:0] PIN_AIN1 = PIN_IDX_W'(1);

  typedef enum logic {
    REQ_SET  = 1'b0,
    REQ_EVAL = 1'b1
  } acef_req_e;

  typedef enum logic [1:0] {
    IRQ_TOGGLE   = 2'd0,
    IRQ_RESERVED = 2'd1,
    IRQ_FALLING  = 2'd2,
    IRQ_RISING   = 2'd3
  } acef_irq_mode_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COMP_DISABLE   = 3'd0,
    REG_BANDGAP_SELECT = 3'd1,
    REG_BANDGAP_LEVEL  = 3'd2,
    REG_IRQ_ENABLE     = 3'd3,
    REG_IRQ_MODE       = 3'd4,
    REG_MUX_ENABLE     = 3'd5,
    REG_ADC_ENABLE     = 3'd6,
    REG_MUX_CHANNEL    = 3'd7
  } acef_reg_e;

  typedef struct packed {
    logic                  comp_disable;
    logic                  bandgap_select;
    logic [CFG_DATA_W-1:0] bandgap_level;
    logic                  irq_enable;
    acef_irq_mode_e        irq_mode;
    logic                  mux_enable;
    logic                  adc_enable;
    logic [CHAN_W-1:0]     mux_channel;
  } acef_cfg_t;

  typedef struct packed {
    acef_req_e            req_type;
    logic [PIN_IDX_W-1:0] pin_index;
    logic [IN_VOLT_W-1:0] pin_voltage;
    logic                 clear_flag;
  } acef_item_t;

endpackage

FILE: src/acef_if.sv
// Channel interfaces: request items, result items and configuration writes.
interface acef_in_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [acef_pkg::PIN_IDX_W-1:0] pin_index;
  logic [acef_pkg::IN_VOLT_W-1:0] pin_voltage;
  logic                           clear_flag;

  modport source (output valid, req_type, pin_index, pin_voltage, clear_flag,
                  input ready);
  modport sink   (input valid, req_type, pin_index, pin_voltage, clear_flag,
                  output ready);
endinterface

interface acef_out_if;
  logic valid;
  logic ready;
  logic comp_output;
  logic irq_flag;
  logic flag_set_now;

  modport source (output valid, comp_output, irq_flag, flag_set_now, input ready);
  modport sink   (input valid, comp_output, irq_flag, flag_set_now, output ready);
endinterface

interface acef_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [acef_pkg::REG_IDX_W-1:0]  reg_index;
  logic [acef_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

FILE: src/acef_pin_file.sv
// Pin voltage register file: one write port, fixed AIN reads, muxed ADC read.
module acef_pin_file #(
  parameter int unsigned VoltBits = acef_pkg::VOLT_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [acef_pkg::PIN_IDX_W-1:0] wr_idx_i,
  input  logic [VoltBits-1:0]            wr_data_i,
  input  logic [acef_pkg::CHAN_W-1:0]    adc_ch_i,
  output logic [VoltBits-1:0]            ain0_o,
  output logic [VoltBits-1:0]            ain1_o,
  output logic [VoltBits-1:0]            adc_o
);
  import acef_pkg::*;

  logic [VoltBits-1:0]  pins_q [PIN_COUNT];
  logic [PIN_IDX_W-1:0] adc_idx;
  logic                 wr_ok;

  // Writes to pin indexes past ADC7 are dropped.
  assign wr_ok   = wr_en_i && (wr_idx_i < PIN_IDX_W'(PIN_COUNT));
  assign adc_idx = PIN_IDX_W'(ADC_BASE) + PIN_IDX_W'(adc_ch_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIN_COUNT; i++) pins_q[i] <= '0;
    end else if (wr_ok) begin
      pins_q[wr_idx_i] <= wr_data_i;
    end
  end

  assign ain0_o = pins_q[PIN_AIN0];
  assign ain1_o = pins_q[PIN_AIN1];
  assign adc_o  = pins_q[adc_idx];

endmodule

FILE: src/analog_comparator_with_edge_flag_unit.sv
// Top level of the analog comparator with edge-triggered sticky interrupt flag.
// The unit accepts one item per cycle and returns one result per item. After the
// input transfer the item is captured in an input register, then the pin read,
// voltage compare and flag update run combinationally and land in the result
// register. Throughput is set by that single evaluate stage, whose
// state (pins, output bit, flag) is written back in the same cycle, so the next
// item sees it without a bubble. Backpressure on the result channel stalls both
// stages; configuration writes are taken every cycle.
`include "analog_comparator_with_edge_flag_unit_assert.svh"

module analog_comparator_with_edge_flag_unit #(
  parameter int unsigned VoltBits = acef_pkg::VOLT_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  acef_in_if.sink           in_i,
  acef_out_if.source        res_o,
  acef_cfg_if.sink          cfg_i
);
  import acef_pkg::*;

  acef_cfg_t           cfg_q;
  acef_item_t          item_q;
  logic                s_valid_q, s_valid_d;
  logic                o_valid_q, o_valid_d;
  logic                comp_q, comp_d;
  logic                irq_q, irq_d;
  logic                res_comp_q, res_irq_q, res_fired_q;
  logic                advance, in_fire, s_fire;
  logic                is_eval, eval_active, new_bit, edge_hit, fired;
  logic [VoltBits-1:0] ain0, ain1, adc, pos_v, neg_v;

  // ---------------- configuration ----------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (acef_reg_e'(cfg_i.reg_index))
        REG_COMP_DISABLE:   cfg_q.comp_disable   <= cfg_i.wdata[0];
        REG_BANDGAP_SELECT: cfg_q.bandgap_select <= cfg_i.wdata[0];
        REG_BANDGAP_LEVEL:  cfg_q.bandgap_level  <= cfg_i.wdata;
        REG_IRQ_ENABLE:     cfg_q.irq_enable     <= cfg_i.wdata[0];
        REG_IRQ_MODE:       cfg_q.irq_mode       <= acef_irq_mode_e'(cfg_i.wdata[1:0]);
        REG_MUX_ENABLE:     cfg_q.mux_enable     <= cfg_i.wdata[0];
        REG_ADC_ENABLE:     cfg_q.adc_enable     <= cfg_i.wdata[0];
        REG_MUX_CHANNEL:    cfg_q.mux_channel    <= cfg_i.wdata[CHAN_W-1:0];
      endcase
    end
  end

  // ---------------- handshake ----------------
  assign advance    = !o_valid_q || res_o.ready;
  assign in_i.ready = !s_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;
  assign s_fire     = s_valid_q && advance;

  assign s_valid_d = in_fire ? 1'b1 : (s_fire ? 1'b0 : s_valid_q);
  assign o_valid_d = s_fire ? 1'b1 : (res_o.ready ? 1'b0 : o_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      s_valid_q <= s_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.req_type    <= acef_req_e'(in_i.req_type);
      item_q.pin_index   <= in_i.pin_index;
      item_q.pin_voltage <= in_i.pin_voltage;
      item_q.clear_flag  <= in_i.clear_flag;
    end
  end

  // ---------------- evaluate stage ----------------
  assign is_eval = (item_q.req_type == REQ_EVAL);

  acef_pin_file #(
    .VoltBits (VoltBits)
  ) u_pins (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (s_fire && !is_eval),
    .wr_idx_i  (item_q.pin_index),
    .wr_data_i (VoltBits'(item_q.pin_voltage)),
    .adc_ch_i  (cfg_q.mux_channel),
    .ain0_o    (ain0),
    .ain1_o    (ain1),
    .adc_o     (adc)
  );

  assign pos_v   = cfg_q.bandgap_select ? VoltBits'(cfg_q.bandgap_level) : ain0;
  assign neg_v   = (cfg_q.mux_enable && !cfg_q.adc_enable) ? adc : ain1;
  assign new_bit = (pos_v > neg_v);

  always_comb begin
    unique case (cfg_q.irq_mode)
      IRQ_TOGGLE:   edge_hit = (new_bit != comp_q);
      IRQ_RESERVED: edge_hit = 1'b0;
      IRQ_FALLING:  edge_hit = !new_bit && comp_q;
      IRQ_RISING:   edge_hit = new_bit && !comp_q;
    endcase
  end

  assign eval_active = is_eval && !cfg_q.comp_disable;
  assign fired       = eval_active && cfg_q.irq_enable && edge_hit;
  assign comp_d      = eval_active ? new_bit : comp_q;
  // software clear comes first, a firing edge then sets the flag again
  assign irq_d       = (irq_q && !(is_eval && item_q.clear_flag)) || fired;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q <= 1'b0;
      irq_q  <= 1'b0;
    end else if (s_fire) begin
      comp_q <= comp_d;
      irq_q  <= irq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      res_comp_q  <= comp_d;
      res_irq_q   <= irq_d;
      res_fired_q <= fired;
    end
  end

  assign res_o.valid        = o_valid_q;
  assign res_o.comp_output  = res_comp_q;
  assign res_o.irq_flag     = res_irq_q;
  assign res_o.flag_set_now = res_fired_q;

  // ---------------- assertions ----------------
  `ACEF_ASSERT_HOLDS(a_fired_sets_flag, clk_i, rst_ni, !(o_valid_q && res_fired_q && !res_irq_q))
  `ACEF_ASSERT_IMPL(a_result_matches_state, clk_i, rst_ni, o_valid_q, (res_comp_q == comp_q) && (res_irq_q == irq_q))
  `ACEF_ASSERT_IMPL(a_stall_only_when_full, clk_i, rst_ni, !in_i.ready, s_valid_q && o_valid_q)
  `ACEF_ASSERT_NEXT(a_set_keeps_comp, clk_i, rst_ni, s_fire && !is_eval, $stable(comp_q) && $stable(irq_q))

endmodule
